// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition must never be seen outside reset
`define ASSERT_NEVER(name, clk, rst, cond, msg) \
   `ASSERT_CLK(name, clk, rst, !(cond), msg)

`endif

// ===== hw/rtl/dmesb_pkg.sv =====
// types and constants of the dual motor speed balance block
package dmesb_pkg;

   localparam int DVD_W     = 57;
   localparam int DVS_W     = 32;
   localparam int DIV_STEPS = DVD_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   localparam logic [6:0]  DUTY_MAX     = 7'd100;
   localparam logic [19:0] USEC_PER_SEC = 20'd1000000;
   localparam logic [3:0]  GAIN_DIV     = 4'd10;

   localparam logic [3:0] GAIN_RESET     = 4'd5;
   localparam logic [3:0] DEADBAND_RESET = 4'd1;
   localparam logic [7:0] PPR_RESET      = 8'd21;

   typedef enum logic [1:0] {
      OP_SET_SPEED = 2'd0,
      OP_EDGE      = 2'd1,
      OP_TICK      = 2'd2,
      OP_NONE      = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CSR_GAIN     = 2'd0,
      CSR_DEADBAND = 2'd1,
      CSR_PPR      = 2'd2,
      CSR_UNUSED   = 2'd3
   } csr_reg_type;

   typedef struct packed {
      logic               start;
      logic [DVD_W-1:0]   dividend;
      logic [DVS_W-1:0]   divisor;
   } div_req_type;

endpackage

// ===== hw/rtl/dmesb_div.sv =====
// bit-serial restoring divider, one quotient bit per cycle
module dmesb_div
   import dmesb_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  div_req_type      div_req,
   output logic             div_done,
   output logic [DVD_W-1:0] div_quo
);

   logic [DVS_W-1:0]     rem_ff, rem_in;
   logic [DVD_W-1:0]     quo_ff, quo_in;
   logic [DVS_W-1:0]     dvs_ff, dvs_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DVS_W:0]       shifted;
   logic [DVS_W+1:0]     diff;

   assign shifted = {rem_ff, quo_ff[DVD_W-1]};
   assign diff    = {1'b0, shifted} - {2'b00, dvs_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (busy_ff) begin
         if (diff[DVS_W+1]) begin
            rem_in = shifted[DVS_W-1:0];
            quo_in = {quo_ff[DVD_W-2:0], 1'b0};
         end else begin
            rem_in = diff[DVS_W-1:0];
            quo_in = {quo_ff[DVD_W-2:0], 1'b1};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (div_req.start) begin
         rem_in  = '0;
         quo_in  = div_req.dividend;
         dvs_in  = div_req.divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign div_done = done_ff;
   assign div_quo  = quo_ff;

endmodule

// ===== hw/rtl/dual_motor_encoder_speed_balance.sv =====
// top level of the dual motor speed balance block
//
//  port group | dir | carries
//  req_*      | in  | op in tuser, motor command or encoder edge in tdata
//  rsp_*      | out | duties, rpm, rotation and flags, one per transaction
//  csr_*      | in  | gain, deadband, pulses per revolution
//
//  set speed, edge and unused op: the result goes through the emit state into the output register
//  tick: no new transaction is accepted until the result is emitted; it waits on the
//  shared 57-step serial divider (up to two divisions per side, one for balancing)
//  and the 20-step serial multiply by one million
//  a new transaction is accepted while a result waits in the output register
//  reset is synchronous and clears the motor and encoder state but for the measured pulse counts
module dual_motor_encoder_speed_balance
   import dmesb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // side, speed_value[7:0], direction, edge_level, timestamp_us[31:0], zero pad
   input  logic [47:0] req_tdata,
   // op[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // out_left_duty[6:0], out_right_duty[6:0], out_left_rpm[15:0],
   // out_right_rpm[15:0], out_left_dir, out_right_dir, left_stalled,
   // right_stalled, speed_error, zero pad
   output logic [55:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [7:0]  csr_wdata
);

`include "assert_macros.svh"

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MEAS,
      ST_MUL,
      ST_DIVF,
      ST_DIVR,
      ST_BAL,
      ST_BALDIV,
      ST_EMIT
   } state_type;

   state_type        state_ff, state_in;

   logic [3:0]       gain_ff, gain_in;
   logic [3:0]       dband_ff, dband_in;
   logic [7:0]       ppr_ff, ppr_in;

   logic [31:0]      cnt_ff [2], cnt_in [2];
   logic [31:0]      tim_ff [2], tim_in [2];
   logic [31:0]      pcnt_ff [2], pcnt_in [2];
   logic [31:0]      ptim_ff [2], ptim_in [2];
   logic [31:0]      pul_ff [2], pul_in [2];
   logic [6:0]       sp_ff [2], sp_in [2];
   logic [6:0]       duty_ff [2], duty_in [2];
   logic [15:0]      rpm_ff [2], rpm_in [2];
   logic             dir_ff [2], dir_in [2];

   logic             side_ff, side_in;
   logic [31:0]      per_ff, per_in;
   logic [51:0]      acc_ff, acc_in;
   logic [51:0]      mcand_ff, mcand_in;
   logic [19:0]      k_ff, k_in;
   logic             neg_ff, neg_in;
   logic             lst_ff, lst_in;
   logic             rst_ff, rst_in;
   logic             err_ff, err_in;

   logic             start_ff, start_in;
   logic [DVD_W-1:0] dvd_ff, dvd_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [55:0]      rsp_data_ff, rsp_data_in;

   div_req_type      div_req;
   logic             div_done;
   logic [DVD_W-1:0] div_quo;

   op_type           req_op;
   logic             req_side;
   logic [7:0]       req_speed;
   logic             req_dir;
   logic [31:0]      req_ts;
   logic [6:0]       speed_clamp;
   logic [31:0]      m_period;
   logic [31:0]      m_pulses;
   logic [32:0]      pdiff;
   logic [31:0]      pmag;
   logic [35:0]      gprod;
   logic [6:0]       corr;
   logic [7:0]       up_l, up_r;
   logic [7:0]       ppr_eff;

   assign req_op    = op_type'(req_tuser);
   assign req_side  = req_tdata[0];
   assign req_speed = req_tdata[8:1];
   assign req_dir   = req_tdata[9];
   assign req_ts    = req_tdata[42:11];

   assign speed_clamp = req_speed[7] ? 7'd0 :
                        (req_speed[6:0] > DUTY_MAX) ? DUTY_MAX : req_speed[6:0];

   assign m_period = tim_ff[side_ff] - ptim_ff[side_ff];
   assign m_pulses = cnt_ff[side_ff] - pcnt_ff[side_ff];

   assign pdiff = {1'b0, pul_ff[0]} - {1'b0, pul_ff[1]};
   assign pmag  = pdiff[32] ? 32'(-pdiff) : pdiff[31:0];
   assign gprod = 36'(pmag) * 36'(gain_ff);

   assign corr    = (|div_quo[DVD_W-1:7]) ? 7'h7f : div_quo[6:0];
   assign up_l    = {1'b0, duty_ff[0]} + {1'b0, corr};
   assign up_r    = {1'b0, duty_ff[1]} + {1'b0, corr};
   assign ppr_eff = (ppr_ff == 8'd0) ? 8'd1 : ppr_ff;

   assign div_req.start    = start_ff;
   assign div_req.dividend = dvd_ff;
   assign div_req.divisor  = dvs_ff;

   dmesb_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .div_done (div_done),
      .div_quo  (div_quo)
   );

   always_comb begin
      state_in     = state_ff;
      gain_in      = gain_ff;
      dband_in     = dband_ff;
      ppr_in       = ppr_ff;
      cnt_in       = cnt_ff;
      tim_in       = tim_ff;
      pcnt_in      = pcnt_ff;
      ptim_in      = ptim_ff;
      pul_in       = pul_ff;
      sp_in        = sp_ff;
      duty_in      = duty_ff;
      rpm_in       = rpm_ff;
      dir_in       = dir_ff;
      side_in      = side_ff;
      per_in       = per_ff;
      acc_in       = acc_ff;
      mcand_in     = mcand_ff;
      k_in         = k_ff;
      neg_in       = neg_ff;
      lst_in       = lst_ff;
      rst_in       = rst_ff;
      err_in       = err_ff;
      start_in     = 1'b0;
      dvd_in       = dvd_ff;
      dvs_in       = dvs_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      if (csr_we) begin
         case (csr_reg_type'(csr_addr))
            CSR_GAIN:     gain_in  = csr_wdata[3:0];
            CSR_DEADBAND: dband_in = csr_wdata[3:0];
            CSR_PPR:      ppr_in   = csr_wdata;
            default:      ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               lst_in   = 1'b0;
               rst_in   = 1'b0;
               err_in   = 1'b0;
               state_in = ST_EMIT;
               case (req_op)
                  OP_SET_SPEED: begin
                     err_in = req_speed[7];
                     if (!(sp_ff[req_side] == speed_clamp && dir_ff[req_side] == req_dir))
                     begin
                        sp_in[req_side]   = speed_clamp;
                        duty_in[req_side] = speed_clamp;
                        dir_in[req_side]  = req_dir;
                     end
                  end
                  OP_EDGE: begin
                     cnt_in[req_side] = cnt_ff[req_side] + 32'd1;
                     tim_in[req_side] = req_ts;
                  end
                  OP_TICK: begin
                     side_in  = 1'b0;
                     state_in = ST_MEAS;
                  end
                  default: ;
               endcase
            end
         end
         ST_MEAS: begin
            pcnt_in[side_ff] = cnt_ff[side_ff];
            ptim_in[side_ff] = tim_ff[side_ff];
            per_in           = m_period;
            if (ptim_ff[side_ff] != 32'd0 && m_period != 32'd0) begin
               pul_in[side_ff] = m_pulses;
               acc_in          = '0;
               mcand_in        = {20'd0, m_pulses};
               k_in            = USEC_PER_SEC;
               state_in        = ST_MUL;
            end else begin
               pul_in[side_ff] = '0;
               rpm_in[side_ff] = '0;
               side_in         = 1'b1;
               state_in        = side_ff ? ST_BAL : ST_MEAS;
            end
         end
         ST_MUL: begin
            if (k_ff == 20'd0) begin
               dvd_in   = {5'd0, acc_ff};
               dvs_in   = per_ff;
               start_in = 1'b1;
               state_in = ST_DIVF;
            end else begin
               if (k_ff[0]) begin
                  acc_in = acc_ff + mcand_ff;
               end
               mcand_in = {mcand_ff[50:0], 1'b0};
               k_in     = {1'b0, k_ff[19:1]};
            end
         end
         ST_DIVF: begin
            if (div_done) begin
               dvd_in   = {div_quo[DVD_W-6:0], 5'd0} - {div_quo[DVD_W-2:0], 1'b0};
               dvs_in   = {24'd0, ppr_eff};
               start_in = 1'b1;
               state_in = ST_DIVR;
            end
         end
         ST_DIVR: begin
            if (div_done) begin
               rpm_in[side_ff] = (|div_quo[DVD_W-1:16]) ? 16'hffff : div_quo[15:0];
               side_in         = 1'b1;
               state_in        = side_ff ? ST_BAL : ST_MEAS;
            end
         end
         ST_BAL: begin
            lst_in   = (sp_ff[0] != 7'd0) && (rpm_ff[0] == 16'd0);
            rst_in   = (sp_ff[1] != 7'd0) && (rpm_ff[1] == 16'd0);
            state_in = ST_EMIT;
            if (sp_ff[0] == sp_ff[1] && sp_ff[0] != 7'd0 && pmag > 32'(dband_ff)) begin
               neg_in   = pdiff[32];
               dvd_in   = DVD_W'(gprod);
               dvs_in   = DVS_W'(GAIN_DIV);
               start_in = 1'b1;
               state_in = ST_BALDIV;
            end
         end
         ST_BALDIV: begin
            if (div_done) begin
               if (!neg_ff) begin
                  duty_in[0] = (corr >= duty_ff[0]) ? 7'd0 : duty_ff[0] - corr;
                  duty_in[1] = (up_r > {1'b0, DUTY_MAX}) ? DUTY_MAX : up_r[6:0];
               end else begin
                  duty_in[0] = (up_l > {1'b0, DUTY_MAX}) ? DUTY_MAX : up_l[6:0];
                  duty_in[1] = (corr >= duty_ff[1]) ? 7'd0 : duty_ff[1] - corr;
               end
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {5'd0, err_ff, rst_ff, lst_ff, dir_ff[1], dir_ff[0],
                               rpm_ff[1], rpm_ff[0], duty_ff[1], duty_ff[0]};
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      per_ff      <= per_in;
      acc_ff      <= acc_in;
      mcand_ff    <= mcand_in;
      k_ff        <= k_in;
      neg_ff      <= neg_in;
      dvd_ff      <= dvd_in;
      dvs_ff      <= dvs_in;
      pul_ff      <= pul_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         gain_ff      <= GAIN_RESET;
         dband_ff     <= DEADBAND_RESET;
         ppr_ff       <= PPR_RESET;
         cnt_ff       <= '{default: '0};
         tim_ff       <= '{default: '0};
         pcnt_ff      <= '{default: '0};
         ptim_ff      <= '{default: '0};
         sp_ff        <= '{default: '0};
         duty_ff      <= '{default: '0};
         rpm_ff       <= '{default: '0};
         dir_ff       <= '{default: '0};
         side_ff      <= 1'b0;
         lst_ff       <= 1'b0;
         rst_ff       <= 1'b0;
         err_ff       <= 1'b0;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gain_ff      <= gain_in;
         dband_ff     <= dband_in;
         ppr_ff       <= ppr_in;
         cnt_ff       <= cnt_in;
         tim_ff       <= tim_in;
         pcnt_ff      <= pcnt_in;
         ptim_ff      <= ptim_in;
         sp_ff        <= sp_in;
         duty_ff      <= duty_in;
         rpm_ff       <= rpm_in;
         dir_ff       <= dir_in;
         side_ff      <= side_in;
         lst_ff       <= lst_in;
         rst_ff       <= rst_in;
         err_ff       <= err_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `ASSERT_NEVER(a_duty_range, clock, reset, duty_ff[0] > DUTY_MAX || duty_ff[1] > DUTY_MAX, "duty above limit")
   `ASSERT_CLK(a_rsp_from_emit, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff) == ST_EMIT, "result without emit")
   `ASSERT_NEVER(a_flag_mix, clock, reset, (lst_ff || rst_ff) && err_ff, "stall and speed error together")

endmodule
